// File: hw/rtl/mmpp_pkg.sv
package mmpp_pkg;

    // Field widths of the stream words.
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_LOG2      = 16;
    localparam int LEN_BITS      = 5;
    localparam int LEVEL_BITS    = 4;
    localparam int INDEX_BITS    = 14;
    localparam int TDATA_BITS    = 56;
    localparam int NUM_LEVELS    = 15;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [LEN_BITS-1:0] MIN_LOG2_LEN   = 5'd2;
    localparam logic [LEN_BITS-1:0] MAX_LOG2_LEN   = 5'd16;
    localparam logic [LEN_BITS-1:0] RESET_LOG2_LEN = 5'd16;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One min/max pair in order of first occurrence.
    typedef struct packed {
        sample_t first;
        sample_t second;
    } pair_t;

    // A level-1 pair handed from the front to the back.
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        pair_t                 pair;
    } fifo_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Reduce four entries to their first minimum and first maximum, in order of position.
    // When both sit at the same position the maximum is placed first.
    function automatic pair_t make_pair(input sample_t g0, input sample_t g1,
                                        input sample_t g2, input sample_t g3);
        sample_t    g [4];
        logic [1:0] lo;
        logic [1:0] hi;
        pair_t      p;
        g[0] = g0;
        g[1] = g1;
        g[2] = g2;
        g[3] = g3;
        lo   = 2'd0;
        hi   = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (g[i] < g[lo])
            begin
                lo = 2'(i);
            end
            if (g[i] > g[hi])
            begin
                hi = 2'(i);
            end
        end
        if (lo < hi)
        begin
            p.first  = g[lo];
            p.second = g[hi];
        end
        else
        begin
            p.first  = g[hi];
            p.second = g[lo];
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/mmpp_front.sv
module mmpp_front
    import mmpp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    restart,
    input  logic [LEN_BITS-1:0]     eff_log2,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_BITS-1:0]  s_axis_tdata,
    input  fifo_stat_t              fifo_stat,
    output logic                    push,
    output fifo_item_t              push_item
);

    logic [MAX_LOG2-1:0] pos_reg;
    logic [MAX_LOG2-1:0] pos_next;
    logic [MAX_LOG2-1:0] frame_last;
    sample_t             samp_reg [3];
    logic                accept;
    logic                group_done;

    // The last position of the frame is 2^L - 1.
    assign frame_last = MAX_LOG2'((( MAX_LOG2 + 1)'(1) << eff_log2) - (MAX_LOG2 + 1)'(1));

    // The fourth word of a group needs room in the queue.
    assign group_done    = (pos_reg[1:0] == 2'd3);
    assign s_axis_tready = !(group_done && fifo_stat.full);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Level-1 pair from the three held samples and the incoming one.
    assign push           = accept && group_done;
    assign push_item.idx  = pos_reg[MAX_LOG2-1:2];
    assign push_item.pair = make_pair(samp_reg[0], samp_reg[1], samp_reg[2],
                                      sample_t'(s_axis_tdata));

    // Frame position advances per word, wraps at the end of the frame and clears on restart.
    always_comb
    begin
        pos_next = pos_reg;
        if (restart)
        begin
            pos_next = '0;
        end
        else if (accept)
        begin
            if (pos_reg == frame_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + MAX_LOG2'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Hold the first three samples of the group.
    always_ff @(posedge clk)
    begin
        if (accept && !group_done)
        begin
            samp_reg[pos_reg[1:0]] <= sample_t'(s_axis_tdata);
        end
    end

endmodule

// File: hw/rtl/mmpp_fifo.sv
module mmpp_fifo
    import mmpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fifo_item_t push_item,
    input  logic       pop,
    output fifo_item_t pop_item,
    output fifo_stat_t stat
);

    fifo_item_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign stat.full  = (count_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - FIFO_CNT_BITS'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/mmpp_back.sv
module mmpp_back
    import mmpp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [LEN_BITS-1:0]    eff_log2,
    input  fifo_stat_t             fifo_stat,
    input  fifo_item_t             pop_item,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_BITS-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic                  cur_valid_reg;
    logic                  cur_valid_next;
    logic [LEVEL_BITS-1:0] cur_level_reg;
    logic [LEVEL_BITS-1:0] cur_level_next;
    logic [INDEX_BITS-1:0] cur_idx_reg;
    logic [INDEX_BITS-1:0] cur_idx_next;
    pair_t                 cur_pair_reg;
    pair_t                 cur_pair_next;
    pair_t                 store_reg [NUM_LEVELS];
    pair_t                 held_pair;
    pair_t                 up_pair;
    logic [LEVEL_BITS-1:0] top_level;
    logic [LEVEL_BITS-1:0] store_addr;
    logic                  chain_end;
    logic                  advance;
    logic                  climb;

    // The top level is L-1; a pair climbs only when it closes the group above.
    assign top_level  = LEVEL_BITS'(eff_log2 - LEN_BITS'(1));
    assign chain_end  = (cur_level_reg == top_level) || !cur_idx_reg[0];
    assign advance    = !cur_valid_reg || m_axis_tready;
    assign climb      = cur_valid_reg && !chain_end;
    assign pop        = advance && !climb && !fifo_stat.empty;

    // The earlier pair of the group one level up waits in the store.
    assign store_addr = cur_level_reg - LEVEL_BITS'(1);
    assign held_pair  = store_reg[store_addr];
    assign up_pair    = make_pair(held_pair.first, held_pair.second,
                                  cur_pair_reg.first, cur_pair_reg.second);

    // Either climb one level or take the next level-1 pair from the queue.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_level_next = cur_level_reg;
        cur_idx_next   = cur_idx_reg;
        cur_pair_next  = cur_pair_reg;
        if (advance)
        begin
            if (climb)
            begin
                cur_valid_next = 1'b1;
                cur_level_next = cur_level_reg + LEVEL_BITS'(1);
                cur_idx_next   = cur_idx_reg >> 1;
                cur_pair_next  = up_pair;
            end
            else if (!fifo_stat.empty)
            begin
                cur_valid_next = 1'b1;
                cur_level_next = LEVEL_BITS'(1);
                cur_idx_next   = pop_item.idx;
                cur_pair_next  = pop_item.pair;
            end
            else
            begin
                cur_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_level_reg <= cur_level_next;
        cur_idx_reg   <= cur_idx_next;
        cur_pair_reg  <= cur_pair_next;
    end

    // A pair that opens its group is kept until its partner arrives.
    always_ff @(posedge clk)
    begin
        if (cur_valid_reg && m_axis_tready && !cur_idx_reg[0])
        begin
            store_reg[store_addr] <= cur_pair_reg;
        end
    end

    // The current pair is the output word.
    assign m_axis_tvalid = cur_valid_reg;
    assign m_axis_tlast  = chain_end;
    assign m_axis_tdata  = {6'd0, cur_pair_reg.second, cur_pair_reg.first,
                            cur_idx_reg, cur_level_reg};

endmodule

// File: hw/rtl/min_max_peak_pyramid.sv
// Min/max peak pyramid: one signed sample word is taken per clock cycle, and for every group of
// four samples a level-1 pair is formed and queued; the back end then emits one pair word per
// cycle while the receiver is ready, climbing one level per cycle while each pair closes the group
// above, so a sample yields up to L-1 words in a row. The level-1 pair of a group passes through
// the pair queue and then the current-pair register before it is valid on the master side. Input
// stalls only when the fourth sample of a group finds the four-entry pair queue full, which
// happens when the receiver holds off, or when a long climb of up to L-1 words outlasts the
// arrival of new pairs, one every four samples. Writing log2_frame_length (clamped to 2..16)
// restarts the frame; there is no clearing pass after reset.
module min_max_peak_pyramid
    import mmpp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LEN_BITS-1:0]    cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] sample
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] level, [17:4] pair_index, [33:18] first_value, [49:34] second_value, zero above
    output logic [TDATA_BITS-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic [LEN_BITS-1:0] log2_len_reg;
    logic [LEN_BITS-1:0] eff_log2;
    logic                push;
    logic                pop;
    fifo_item_t          push_item;
    fifo_item_t          pop_item;
    fifo_stat_t          fifo_stat;

    // Frame length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_len_reg <= RESET_LOG2_LEN;
        end
        else if (cfg_we)
        begin
            log2_len_reg <= cfg_wdata;
        end
    end

    // Clamp to the supported range.
    always_comb
    begin
        if (log2_len_reg < MIN_LOG2_LEN)
        begin
            eff_log2 = MIN_LOG2_LEN;
        end
        else if (log2_len_reg > MAX_LOG2_LEN)
        begin
            eff_log2 = MAX_LOG2_LEN;
        end
        else
        begin
            eff_log2 = log2_len_reg;
        end
    end

    mmpp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (cfg_we),
        .eff_log2      (eff_log2),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .push_item     (push_item)
    );

    mmpp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    mmpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .eff_log2      (eff_log2),
        .fifo_stat     (fifo_stat),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/mmpp_checker.sv
module mmpp_checker
    import mmpp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [TDATA_BITS-1:0]  m_axis_tdata,
    input  logic                   m_axis_tlast
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Every pair word carries a level of at least one.
    a_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd0)
        else $error("pair word with level zero");

    // A pair only climbs when it closes its group, so its index is odd.
    a_climb_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[4])
        else $error("non-final pair with even index");

    // The next pair of the same sample follows at once, one level up.
    a_climb_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
        else $error("pair chain broken");

endmodule

bind min_max_peak_pyramid mmpp_checker u_mmpp_checker (.*);

// File: tb/min_max_peak_pyramid_tb.sv
`timescale 1ns / 100ps

module min_max_peak_pyramid_tb;

    import mmpp_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 40;

    // Frame lengths swept by the random part, out-of-range values among them.
    localparam logic [LEN_BITS-1:0] SWEEP [16] = '{
        5'd3, 5'd4, 5'd1, 5'd5, 5'd6, 5'd8, 5'd31, 5'd7,
        5'd2, 5'd0, 5'd17, 5'd16, 5'd4, 5'd3, 5'd10, 5'd12
    };

    // One expected pair word, fields as they appear on the master side.
    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [INDEX_BITS-1:0] idx;
        sample_t               first;
        sample_t               second;
        logic                  last;
    } pair_word_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [LEN_BITS-1:0]    cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]  m_tdata;
    logic                   m_tlast;

    sample_t    samples_to_send [$];
    pair_word_t pending_pairs [$];

    // Shadow of the pyramid state.
    logic [LEN_BITS-1:0] len_reg = RESET_LOG2_LEN;
    sample_t             tier_vals [NUM_LEVELS][4];
    int                  tier_fill [NUM_LEVELS];
    int unsigned         frame_pos = 0;

    int  errors        = 0;
    int  stall_cycles  = 0;
    int  src_wait      = 0;
    int  rx_wait       = 0;
    int  hold_left     = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    bit  src_quiet     = 1'b0;
    bit  rx_quiet      = 1'b0;
    bit  src_fast      = 1'b0;

    min_max_peak_pyramid i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // Frame length after clamping to the supported range.
    function automatic int effective_length();
        if (len_reg < MIN_LOG2_LEN)
        begin
            return int'(MIN_LOG2_LEN);
        end
        if (len_reg > MAX_LOG2_LEN)
        begin
            return int'(MAX_LOG2_LEN);
        end
        return int'(len_reg);
    endfunction

    function automatic void restart_frame();
        frame_pos = 0;
        for (int t = 0; t < NUM_LEVELS; t++)
        begin
            tier_fill[t] = 0;
        end
    endfunction

    // First minimum and first maximum of a full group, in order of position;
    // when both are found at the same position the maximum goes first.
    function automatic void order_extremes(input int t, output sample_t early,
                                           output sample_t later);
        int lo_at;
        int hi_at;
        lo_at = 0;
        hi_at = 0;
        for (int i = 1; i < 4; i++)
        begin
            if (tier_vals[t][i] < tier_vals[t][lo_at])
            begin
                lo_at = i;
            end
            if (tier_vals[t][i] > tier_vals[t][hi_at])
            begin
                hi_at = i;
            end
        end
        if (lo_at < hi_at)
        begin
            early = tier_vals[t][lo_at];
            later = tier_vals[t][hi_at];
        end
        else
        begin
            early = tier_vals[t][hi_at];
            later = tier_vals[t][lo_at];
        end
    endfunction

    // Feed one sample into the shadow pyramid and queue the pairs it closes.
    function automatic void absorb_sample(input sample_t s);
        int          span;
        int unsigned pos;
        int          tier;
        int          slot;
        bit          closed;
        bit          have_held;
        sample_t     a;
        sample_t     b;
        pair_word_t  held;
        span      = effective_length();
        pos       = frame_pos;
        have_held = 1'b0;
        held      = '0;
        slot      = tier_fill[0] % 4;
        tier_vals[0][slot] = s;
        tier_fill[0] = slot + 1;
        closed = (slot == 3);
        tier   = 1;
        while (closed && tier <= span - 1)
        begin
            order_extremes(tier - 1, a, b);
            tier_fill[tier - 1] = 0;
            if (have_held)
            begin
                pending_pairs.push_back(held);
            end
            held.level  = LEVEL_BITS'(tier);
            held.idx    = INDEX_BITS'(pos >> (tier + 1));
            held.first  = a;
            held.second = b;
            held.last   = 1'b0;
            have_held   = 1'b1;
            closed      = 1'b0;
            // Climb one level: the new pair fills half a group above.
            if (tier < span - 1)
            begin
                slot = tier_fill[tier];
                tier_vals[tier][slot]     = a;
                tier_vals[tier][slot + 1] = b;
                tier_fill[tier] = slot + 2;
                closed = (slot == 2);
            end
            tier++;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            pending_pairs.push_back(held);
        end
        if (pos >= (32'd1 << span) - 1)
        begin
            restart_frame();
        end
        else
        begin
            frame_pos = pos + 1;
        end
    endfunction

    // Wait cycles for one word; each side now and then switches to a run with no gaps.
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 31) == 0)
        begin
            quiet = !quiet;
        end
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Random sample mixing the extremes, small values that tie, and the full range.
    function automatic sample_t draw_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(16'h7FFF);
            1:       return sample_t'(16'h8000);
            2, 3:    return sample_t'(int'($urandom_range(0, 6)) - 3);
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    // Sender: offers queued samples with a random gap after each word.
    always @(posedge clk or negedge rst_n)
    begin : sender
        int gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_wait <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_wait != 0)
            begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end
            else if (samples_to_send.size() != 0)
            begin
                gap = draw_gap(src_quiet);
                s_tvalid <= 1'b1;
                s_tdata  <= samples_to_send.pop_front();
                src_wait <= src_fast ? 0 : gap;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls after each word, and a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int gap;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            rx_wait     <= 0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            gap = draw_gap(rx_quiet);
            rx_wait  <= gap;
            m_tready <= (gap == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted sample, then check every accepted pair word.
    always @(posedge clk)
    begin : monitor
        pair_word_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            absorb_sample(sample_t'(s_tdata));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t ns: expected no pair word, got %h", $time, m_tdata);
                end
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (m_tdata[3:0] !== want.level)
                begin
                    report_mismatch("level", int'(want.level), int'(m_tdata[3:0]));
                end
                if (m_tdata[17:4] !== want.idx)
                begin
                    report_mismatch("pair_index", int'(want.idx), int'(m_tdata[17:4]));
                end
                if (m_tdata[33:18] !== want.first)
                begin
                    report_mismatch("first_value", int'(want.first),
                                    int'(sample_t'(m_tdata[33:18])));
                end
                if (m_tdata[49:34] !== want.second)
                begin
                    report_mismatch("second_value", int'(want.second),
                                    int'(sample_t'(m_tdata[49:34])));
                end
                if (m_tdata[TDATA_BITS-1:50] !== '0)
                begin
                    report_mismatch("padding", 0, int'(m_tdata[TDATA_BITS-1:50]));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("last", int'(want.last), int'(m_tlast));
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Register writes happen only while the block is idle.
    task automatic write_length(input logic [LEN_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_reg = value;
        restart_frame();
    endtask

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            samples_to_send.push_back(draw_sample());
        end
    endtask

    // Wait until every sample is taken and every pair has come out, then let the block settle.
    task automatic settle();
        while (samples_to_send.size() != 0 || s_tvalid || pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_group(input logic [15:0] v0, input logic [15:0] v1,
                              input logic [15:0] v2, input logic [15:0] v3);
        samples_to_send.push_back(sample_t'(v0));
        samples_to_send.push_back(sample_t'(v1));
        samples_to_send.push_back(sample_t'(v2));
        samples_to_send.push_back(sample_t'(v3));
    endtask

    initial
    begin
        restart_frame();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Part of a frame at the reset length.
        feed_random(40);
        settle();

        // Shortest frame: maximum before minimum, minimum before maximum, all equal,
        // repeated extremes, and alternating bit patterns.
        write_length(5'd2);
        push_group(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        push_group(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
        push_group(16'h0007, 16'h0007, 16'h0007, 16'h0007);
        push_group(16'hFFFB, 16'h0003, 16'hFFFB, 16'h0003);
        push_group(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        settle();

        // A write in the middle of a frame, then a length below the range.
        write_length(5'd3);
        push_group(16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0);
        samples_to_send.push_back(sample_t'(16'h1234));
        settle();
        write_length(5'd0);
        push_group(16'h0002, 16'h0001, 16'h0003, 16'h0000);
        settle();

        // Random sweep over frame lengths; one phase holds the receiver off for long.
        for (int p = 0; p < 16; p++)
        begin
            write_length(SWEEP[p]);
            if (SWEEP[p] == 5'd8)
            begin
                hold_requests++;
                feed_random(120);
            end
            else
            begin
                feed_random($urandom_range(6, 20));
            end
            settle();
        end

        // Words back to back at the largest length, written above the range.
        src_fast = 1'b1;
        write_length(5'd20);
        feed_random(36);
        settle();
        src_fast = 1'b0;

        if (errors == 0 && pending_pairs.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mmpp_pkg.sv
hw/rtl/mmpp_front.sv
hw/rtl/mmpp_fifo.sv
hw/rtl/mmpp_back.sv
hw/rtl/min_max_peak_pyramid.sv
hw/rtl/mmpp_checker.sv
tb/min_max_peak_pyramid_tb.sv
